/* src/mhpq_pkg.sv */
`default_nettype none

package mhpq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 64;
  localparam int unsigned KEY_WIDTH_DEF  = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_POP,
    OP_FULL,
    OP_EMPTY
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UP_RD,
    BK_UP_WR,
    BK_POP_RD,
    BK_POP_LD,
    BK_DN_RD,
    BK_DN_WR,
    BK_DONE
  } bk_state_e;

endpackage

`default_nettype wire

/* src/min_heap_priority_queue_top.sv */
// Flow: once the back end is free, an insert reads the parent and then writes one entry
// per level the key climbs; a pop reads the root and the last entry, loads them, then reads
// and writes per level the key sinks; a dropped insert or an empty pop goes to the result.
// Throughput: one transaction per back-end run, and a held output stalls the run; the
// single heap memory and its read-then-write step per level set the length of a run.
// Reset empties the heap and the two-entry command queue; heap memory is not cleared.
`default_nettype none

module min_heap_priority_queue_top import mhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = KEY_WIDTH_DEF,
  localparam int unsigned CntW      = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]  popped_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [CntW-1:0]            entry_count_o
);

  localparam int unsigned PktW = OP_W + KEY_WIDTH + 2 * CntW;

  logic            push;
  logic [PktW-1:0] push_data;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic [PktW-1:0] q_data;

  mhpq_front #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .CntW       (CntW),
    .PktW       (PktW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  mhpq_queue #(
    .Width (PktW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  mhpq_back #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .CntW       (CntW),
    .PktW       (PktW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

`default_nettype wire

/* src/mhpq_queue.sv */
`default_nettype none

module mhpq_queue import mhpq_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  logic [Width-1:0] slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (fill_q == FillW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* src/mhpq_front.sv */
`default_nettype none

module mhpq_front import mhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = KEY_WIDTH_DEF,
  parameter int unsigned CntW       = $clog2(HEAP_DEPTH + 1),
  parameter int unsigned PktW       = OP_W + KEY_WIDTH + 2 * CntW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       push_o,
  output logic [PktW-1:0]            push_data_o,
  input  logic                       q_full_i
);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      cnt_after;
  logic [KEY_WIDTH-1:0] key;
  op_e                  op;
  logic                 accept;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i;
  assign accept     = in_valid_i && !q_full_i;
  assign key        = KEY_WIDTH'(64'($unsigned(value_i)));

  always_comb begin
    if (cmd_i == CMD_INSERT) begin
      if (cnt_q == CntW'(HEAP_DEPTH)) begin
        op        = OP_FULL;
        cnt_after = cnt_q;
      end else begin
        op        = OP_INSERT;
        cnt_after = cnt_q + CntW'(1);
      end
    end else begin
      if (cnt_q == '0) begin
        op        = OP_EMPTY;
        cnt_after = '0;
      end else begin
        op        = OP_POP;
        cnt_after = cnt_q - CntW'(1);
      end
    end
  end

  assign push_data_o = {op, key, cnt_q, cnt_after};
  assign cnt_d       = accept ? cnt_after : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* src/mhpq_back.sv */
`default_nettype none

module mhpq_back import mhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = KEY_WIDTH_DEF,
  parameter int unsigned CntW       = $clog2(HEAP_DEPTH + 1),
  parameter int unsigned PktW       = OP_W + KEY_WIDTH + 2 * CntW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  logic [PktW-1:0]            q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]  popped_value_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [CntW-1:0]            entry_count_o
);

  localparam int unsigned AddrW = $clog2(HEAP_DEPTH);

  logic [KEY_WIDTH-1:0] mem [HEAP_DEPTH];
  logic [KEY_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                 we;
  logic [AddrW-1:0]     waddr, raddr_a, raddr_b;
  logic [KEY_WIDTH-1:0] wdata;

  bk_state_e            state_q, state_d;
  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] popped_q, popped_d;
  logic [AddrW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]      lim_q, lim_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_popped_q, out_popped_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;
  logic [CntW-1:0]           out_count_q, out_count_d;

  op_e                  q_op;
  logic [KEY_WIDTH-1:0] q_key;
  logic [CntW-1:0]      q_cnt_before, q_cnt_after;

  logic [AddrW-1:0]     parent;
  logic [AddrW:0]       kid, kid_r, lim_x, cidx;
  logic                 pick_r;
  logic [KEY_WIDTH-1:0] child;
  logic                 up_move, dn_move;
  logic                 load_out;

  assign q_op         = op_e'(q_data_i[PktW-1 -: OP_W]);
  assign q_key        = q_data_i[2*CntW +: KEY_WIDTH];
  assign q_cnt_before = q_data_i[CntW +: CntW];
  assign q_cnt_after  = q_data_i[0 +: CntW];

  assign parent  = (pos_q - AddrW'(1)) >> 1;
  assign kid     = {pos_q, 1'b1};
  assign kid_r   = kid + (AddrW + 1)'(1);
  assign lim_x   = (AddrW + 1)'(lim_q);
  assign pick_r  = (kid_r < lim_x) && ($signed(rd_b_q) < $signed(rd_a_q));
  assign child   = pick_r ? rd_b_q : rd_a_q;
  assign cidx    = pick_r ? kid_r : kid;
  assign up_move = $signed(rd_a_q) > $signed(key_q);
  assign dn_move = $signed(key_q) > $signed(child);

  assign load_out = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          unique case (q_op)
            OP_INSERT: state_d = BK_UP_RD;
            OP_POP:    state_d = BK_POP_RD;
            OP_FULL:   state_d = BK_DONE;
            OP_EMPTY:  state_d = BK_DONE;
          endcase
        end
      end
      BK_UP_RD:  state_d = (pos_q == '0) ? BK_DONE : BK_UP_WR;
      BK_UP_WR:  state_d = up_move ? BK_UP_RD : BK_DONE;
      BK_POP_RD: state_d = BK_POP_LD;
      BK_POP_LD: state_d = (lim_q == '0) ? BK_DONE : BK_DN_RD;
      BK_DN_RD:  state_d = (kid >= lim_x) ? BK_DONE : BK_DN_WR;
      BK_DN_WR:  state_d = dn_move ? BK_DN_RD : BK_DONE;
      BK_DONE:   state_d = load_out ? BK_IDLE : BK_DONE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o      = 1'b0;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = key_q;
    raddr_a      = '0;
    raddr_b      = '0;
    op_d         = op_q;
    key_d        = key_q;
    popped_d     = popped_q;
    pos_d        = pos_q;
    lim_d        = lim_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_popped_d = out_popped_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          op_d     = q_op;
          key_d    = q_key;
          pos_d    = AddrW'(q_cnt_before);
          lim_d    = q_cnt_after;
          popped_d = '0;
        end
      end
      BK_UP_RD: begin
        if (pos_q == '0) begin
          we = 1'b1;
        end else begin
          raddr_a = parent;
        end
      end
      BK_UP_WR: begin
        we = 1'b1;
        if (up_move) begin
          wdata = rd_a_q;
          pos_d = parent;
        end
      end
      BK_POP_RD: begin
        raddr_a = '0;
        raddr_b = AddrW'(lim_q);
      end
      BK_POP_LD: begin
        popped_d = rd_a_q;
        key_d    = rd_b_q;
        pos_d    = '0;
      end
      BK_DN_RD: begin
        if (kid >= lim_x) begin
          we = 1'b1;
        end else begin
          raddr_a = AddrW'(kid);
          raddr_b = AddrW'(kid_r);
        end
      end
      BK_DN_WR: begin
        we = 1'b1;
        if (dn_move) begin
          wdata = child;
          pos_d = AddrW'(cidx);
        end
      end
      BK_DONE: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          out_popped_d = (op_q == OP_POP) ? VALUE_W'(64'($signed(popped_q))) : '0;
          out_count_d  = lim_q;
          unique case (op_q)
            OP_FULL:  out_status_d = ST_FULL;
            OP_EMPTY: out_status_d = ST_EMPTY;
            OP_INSERT: out_status_d = ST_OK;
            OP_POP:   out_status_d = ST_OK;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    popped_q     <= popped_d;
    pos_q        <= pos_d;
    lim_q        <= lim_d;
    out_popped_q <= out_popped_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_popped_q;
  assign status_o       = out_status_q;
  assign entry_count_o  = out_count_q;

endmodule

`default_nettype wire

/* src/mhpq_checker.sv */
`default_nettype none

module mhpq_checker import mhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned CntW       = $clog2(HEAP_DEPTH + 1)
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_i,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic signed [VALUE_W-1:0] popped_value_i,
  input logic [STATUS_W-1:0]       status_i,
  input logic [CntW-1:0]           entry_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(popped_value_i) &&
      $stable(status_i) && $stable(entry_count_i))
    else $error("Stalled result changed.");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_i |=> in_valid_i)
    else $error("Stalled transaction withdrawn.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |->
      (entry_count_i == CntW'(HEAP_DEPTH)) && (popped_value_i == '0))
    else $error("Dropped insert without a full heap.");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |->
      (entry_count_i == '0) && (popped_value_i == '0))
    else $error("Empty pop reported a nonzero count or value.");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i && !in_stall_i)
    else $error("Result pending or input stalled right after reset.");

endmodule

bind min_heap_priority_queue_top mhpq_checker #(
  .HEAP_DEPTH (HEAP_DEPTH)
) u_mhpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .popped_value_i (popped_value_o),
  .status_i       (status_o),
  .entry_count_i  (entry_count_o)
);

`default_nettype wire
